@@ hdl/cbf2_pkg.sv @@
// ----------------------------------------------------------------------------
// cbf2_pkg
// Types, codes and the digest expander step shared by the counting Bloom
// filter with 2-bit counters.
// ----------------------------------------------------------------------------
package cbf2_pkg;

    localparam int unsigned ROT_A = 37;
    localparam int unsigned ROT_B = 8;

    localparam logic [4:0] LOG_SLOTS_RESET = 5'd16;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_TEST   = 2'd2;

    localparam logic [1:0] CNT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } digest_t;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic digest_t expand_step(input digest_t d);
        digest_t n;
        n.lo = d.lo ^ rotl(d.hi, ROT_A);
        n.hi = d.hi + rotl(n.lo, ROT_B);
        return n;
    endfunction

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        return (c >= CNT_FULL) ? CNT_FULL : c + 2'd1;
    endfunction

endpackage

@@ hdl/cbf2_ram.sv @@
// ----------------------------------------------------------------------------
// cbf2_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read of the address written in the same cycle
// returns the old data.
// ----------------------------------------------------------------------------
module cbf2_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/counting_bloom_filter_2bit.sv @@
// ----------------------------------------------------------------------------
// counting_bloom_filter_2bit
// Counting Bloom filter with 2-bit counters that saturate at 2.
// ----------------------------------------------------------------------------
// Each request on the s_ channel carries a 128-bit key digest in s_tdata and
// its kind in s_tuser: clear table, insert key or test key. Every request
// gives exactly one response on the m_ channel; m_tdata bit 0 is the hit
// flag, set only for a test whose counters are all saturated.
// The digest is expanded into HASH_COUNT slot indices, one expander step per
// cycle. The counters live in a dual-port RAM with a registered read; each
// slot is read, incremented and written back while the next slot is read,
// with forwarding on an insert when two consecutive slots of one key coincide.
// Insert and test load the response once the last slot has been checked or
// updated; a new request is taken only after the response is loaded. Clear
// walks the whole RAM, one entry a cycle, and then loads its response.
// After reset the same sweep runs over the whole RAM with s_tready low;
// configuration writes are taken at any time on the cfg_ channel.
// The response waits in an output register; a stalled receiver holds the
// block in its final step, and s_tready rises once the response is loaded.
// ----------------------------------------------------------------------------
module counting_bloom_filter_2bit
    import cbf2_pkg::*;
#(
    parameter int LOG_SLOTS_MAX = 16,
    parameter int HASH_COUNT    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,    // digest_low [63:0], digest_high [127:64]
    input  logic [1:0]    s_tuser,    // kind [1:0]

    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,    // hit [0], zero fill [7:1]

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data    // log_slots [4:0]
);

    localparam int ADDR_W = LOG_SLOTS_MAX;
    localparam int CNT_W  = $clog2(HASH_COUNT + 1);

    state_t              state_reg, state_next;
    digest_t             dig_reg, dig_next;
    logic [1:0]          kind_reg, kind_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                fwd_reg, fwd_next;
    logic [1:0]          fwd_data_reg, fwd_data_next;
    logic                hit_acc_reg, hit_acc_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic                clear_pend_reg, clear_pend_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_hit_reg, m_hit_next;
    logic [4:0]          log_slots_reg, log_slots_next;

    logic [4:0]          live_log;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   slot;
    logic [1:0]          cur_cnt;
    logic [1:0]          inc_cnt;
    logic                issue;
    logic                accept;
    logic                out_free;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [1:0]          ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [1:0]          ram_rdata;

    cbf2_ram #(
        .WIDTH (2),
        .DEPTH (2 ** LOG_SLOTS_MAX)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_hit_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        if (log_slots_reg == 5'd0) begin
            live_log = 5'd1;
        end else if (log_slots_reg > 5'(LOG_SLOTS_MAX)) begin
            live_log = 5'(LOG_SLOTS_MAX);
        end else begin
            live_log = log_slots_reg;
        end
        for (int i = 0; i < ADDR_W; i++) begin
            mask[i] = (5'(i) < live_log);
        end
    end

    assign slot    = dig_reg.lo[ADDR_W:1] & mask;
    assign cur_cnt = fwd_reg ? fwd_data_reg : ram_rdata;
    assign inc_cnt = sat_inc(cur_cnt);
    assign issue   = (state_reg == ST_RUN) && (rd_cnt_reg < CNT_W'(HASH_COUNT));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sweep_reg == {ADDR_W{1'b1}}) begin
                    state_next = clear_pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_CLEAR) begin
                        state_next = ST_SWEEP;
                    end else if (s_tuser == KIND_INSERT || s_tuser == KIND_TEST) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                if (!issue && pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = state_reg;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = inc_cnt;
        ram_raddr = slot;
        unique case (state_reg)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = 2'd0;
            end
            ST_RUN: begin
                ram_we = pend_reg && (kind_reg == KIND_INSERT);
            end
            ST_IDLE, ST_DONE: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        dig_next        = dig_reg;
        kind_next       = kind_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        fwd_next        = 1'b0;
        fwd_data_next   = fwd_data_reg;
        hit_acc_next    = hit_acc_reg;
        sweep_next      = sweep_reg;
        clear_pend_next = clear_pend_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_hit_next      = m_hit_reg;
        log_slots_next  = cfg_valid ? cfg_data : log_slots_reg;

        if (state_reg == ST_SWEEP) begin
            sweep_next = sweep_reg + ADDR_W'(1);
        end

        if (accept) begin
            dig_next        = '{hi: s_tdata[127:64], lo: s_tdata[63:0]};
            kind_next       = s_tuser;
            rd_cnt_next     = '0;
            hit_acc_next    = (s_tuser == KIND_TEST);
            sweep_next      = '0;
            clear_pend_next = 1'b1;
        end

        if (state_reg == ST_RUN) begin
            if (pend_reg) begin
                hit_acc_next = hit_acc_reg && (cur_cnt == CNT_FULL);
            end
            if (issue) begin
                dig_next       = expand_step(dig_reg);
                rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                pend_next      = 1'b1;
                pend_addr_next = slot;
                fwd_next       = pend_reg && (kind_reg == KIND_INSERT)
                                 && (slot == pend_addr_reg);
                fwd_data_next  = inc_cnt;
            end
        end

        if (state_reg == ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            m_hit_next    = hit_acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            fwd_reg        <= 1'b0;
            sweep_reg      <= '0;
            clear_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            log_slots_reg  <= LOG_SLOTS_RESET;
        end else begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            fwd_reg        <= fwd_next;
            sweep_reg      <= sweep_next;
            clear_pend_reg <= clear_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            log_slots_reg  <= log_slots_next;
        end
        dig_reg       <= dig_next;
        kind_reg      <= kind_next;
        pend_addr_reg <= pend_addr_next;
        fwd_data_reg  <= fwd_data_next;
        hit_acc_reg   <= hit_acc_next;
        m_hit_reg     <= m_hit_next;
    end

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_we)
        else $error("counter RAM written outside an update step");

    a_rd_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_cnt_reg <= CNT_W'(HASH_COUNT))
        else $error("slot read count beyond hash count");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("request accepted without starting work");

    a_fwd_insert_only: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> (kind_reg == KIND_INSERT && pend_reg))
        else $error("forwarding outside an insert");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (state_reg != ST_IDLE || $past(state_reg) != ST_DONE))
        else $error("response loaded over a waiting response");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the 2-bit counting Bloom filter. A scoreboard keeps
// its own counter table and slot mask, predicts the hit flag of every
// accepted request and checks each response in order. Stimulus is a short
// directed run, then phases of random insert/test sequences over a small key
// pool under changing slot counts and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbf2_pkg::*;

    localparam int LOG_SLOTS_MAX = 16;
    localparam int HASH_COUNT    = 4;
    localparam int SLOT_DEPTH    = 1 << LOG_SLOTS_MAX;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 140;
    localparam int POOL_SIZE     = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class bloom_scoreboard;
        bit [1:0]   counters [SLOT_DEPTH];
        logic [4:0] log_slots;
        bit         hit_queue [$];
        int         mismatches;

        function new();
            log_slots  = LOG_SLOTS_RESET;
            mismatches = 0;
            foreach (counters[i]) counters[i] = 2'd0;
        endfunction

        function void set_log_slots(input logic [4:0] value);
            log_slots = value;
        endfunction

        function int pending();
            return hit_queue.size();
        endfunction

        function void note_request(input logic [1:0] kind, input logic [63:0] lo_in,
                                   input logic [63:0] hi_in);
            int          width;
            int          j;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mask;
            logic [63:0] slot [HASH_COUNT];
            bit          all_full;
            width = int'(log_slots);
            if (width < 1) width = 1;
            if (width > LOG_SLOTS_MAX) width = LOG_SLOTS_MAX;
            mask = (64'd1 << width) - 64'd1;
            lo = lo_in;
            hi = hi_in;
            for (j = 0; j < HASH_COUNT; j++) begin
                slot[j] = (lo >> 1) & mask;
                lo = lo ^ {hi[26:0], hi[63:27]};
                hi = hi + {lo[55:0], lo[63:56]};
            end
            all_full = 1'b1;
            case (kind)
                KIND_CLEAR: begin
                    foreach (counters[i]) counters[i] = 2'd0;
                end
                KIND_INSERT: begin
                    for (j = 0; j < HASH_COUNT; j++)
                        if (counters[slot[j]] != CNT_FULL)
                            counters[slot[j]] = counters[slot[j]] + 2'd1;
                end
                KIND_TEST: begin
                    for (j = 0; j < HASH_COUNT; j++)
                        if (counters[slot[j]] != CNT_FULL) all_full = 1'b0;
                end
                default: begin
                end
            endcase
            hit_queue.push_back((kind == KIND_TEST) && all_full);
        endfunction

        function void check_response(input logic [7:0] data);
            bit want;
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: m_tdata=%02h", data);
                return;
            end
            want = hit_queue.pop_front();
            if (data !== {7'd0, want}) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("hit mismatch: expected %02h, actual %02h", {7'd0, want}, data);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [4:0]   cfg_data;

    bloom_scoreboard board;
    int          tx_idle_pct = 6;
    int          rx_idle_pct = 71;
    int          hold_left = 0;
    int          requests_sent = 0;
    int          responses_seen = 0;
    int          cycles = 0;
    logic [63:0] pool_lo [POOL_SIZE];
    logic [63:0] pool_hi [POOL_SIZE];

    counting_bloom_filter_2bit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_log_slots(cfg_data);
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata[63:0], s_tdata[127:64]);
            if (m_tvalid && m_tready) begin
                board.check_response(m_tdata);
                responses_seen++;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [63:0] lo,
                                input logic [63:0] hi);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (responses_seen != requests_sent) @(posedge aclk);
    endtask

    task automatic write_log_slots(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        logic [63:0] ones;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        ones   = '1;
        key_lo = random_word();
        key_hi = random_word();
        // The all-zero digest maps every hash to one slot, so a single
        // insert already saturates it.
        send_request(KIND_TEST,   64'd0, 64'd0);
        send_request(KIND_INSERT, 64'd0, 64'd0);
        send_request(KIND_TEST,   64'd0, 64'd0);
        send_request(KIND_INSERT, 64'd0, 64'd0);
        send_request(KIND_TEST,   ones,  ones);
        send_request(KIND_INSERT, ones,  ones);
        send_request(KIND_INSERT, ones,  ones);
        send_request(KIND_TEST,   ones,  ones);
        send_request(KIND_TEST,   ones,  64'd0);
        send_request(KIND_TEST,   64'd0, ones);
        send_request(KIND_UNUSED, ones,  ones);
        send_request(KIND_UNUSED, 64'd0, 64'd0);
        send_request(KIND_TEST,   64'd0, 64'd0);
        send_request(KIND_CLEAR,  ones,  ones);
        send_request(KIND_TEST,   64'd0, 64'd0);
        send_request(KIND_TEST,   ones,  ones);
        send_request(KIND_INSERT, key_lo, key_hi);
        send_request(KIND_TEST,   key_lo, key_hi);
        send_request(KIND_INSERT, key_lo, key_hi);
        send_request(KIND_TEST,   key_lo, key_hi);
    endtask

    task automatic run_random_phase(input int phase);
        int          sent_here;
        int          pick;
        int          k;
        int          reps;
        bit          pressed;
        logic [4:0]  log_value;
        case (phase)
            0: log_value = 5'd1;
            1: log_value = 5'd16;
            2: log_value = 5'd0;
            3: log_value = 5'd31;
            4: log_value = 5'd2;
            5: log_value = 5'd3;
            6: log_value = 5'($urandom_range(31));
            7: log_value = 5'd4;
            default: log_value = 5'd1;
        endcase
        case (phase / 3)
            0: begin
                tx_idle_pct = 6;
                rx_idle_pct = 71;
            end
            1: begin
                tx_idle_pct = 71;
                rx_idle_pct = 6;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
        wait_drained();
        write_log_slots(log_value);
        pool_lo[0] = '0;
        pool_hi[0] = '0;
        pool_lo[1] = '1;
        pool_hi[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) begin
            pool_lo[k] = random_word();
            pool_hi[k] = random_word();
        end
        sent_here = 0;
        pressed   = 1'b0;
        while (sent_here < PHASE_ITEMS) begin
            if (!pressed && sent_here >= PHASE_ITEMS / 2) begin
                pressed = 1'b1;
                if (phase % 2 == 0) hold_left = HOLD_CYCLES;
                else wait_drained();
            end
            pick = $urandom_range(99);
            k    = $urandom_range(POOL_SIZE - 1);
            if (pick < 50) begin
                reps = $urandom_range(2, 1);
                repeat (reps) send_request(KIND_INSERT, pool_lo[k], pool_hi[k]);
                if ($urandom_range(3) == 0) k = $urandom_range(POOL_SIZE - 1);
                send_request(KIND_TEST, pool_lo[k], pool_hi[k]);
                sent_here += reps + 1;
            end else if (pick < 75) begin
                if ($urandom_range(1) == 0)
                    send_request(KIND_TEST, pool_lo[k], pool_hi[k]);
                else
                    send_request(KIND_TEST, random_word(), random_word());
                sent_here++;
            end else if (pick < 90) begin
                send_request(KIND_INSERT, random_word(), random_word());
                sent_here++;
            end else if (pick < 99) begin
                send_request(KIND_UNUSED, random_word(), random_word());
                sent_here++;
            end else begin
                if ($urandom_range(2) == 0)
                    send_request(KIND_CLEAR, random_word(), random_word());
                else
                    send_request(KIND_TEST, random_word(), random_word());
                sent_here++;
            end
        end
    endtask

    initial begin
        int phase;
        board = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_CLEAR;
        cfg_valid <= 1'b0;
        cfg_data  <= LOG_SLOTS_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (phase = 0; phase < PHASES; phase++) run_random_phase(phase);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
